>>> sv/lprbl_pkg.sv
// shared types and constants for the lidar range image box labeller
// no dependencies
`default_nettype none
package lprbl_pkg;

  localparam int unsigned CoordBits   = 16;
  localparam int unsigned ScaleShift  = 12;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned SqrtSteps   = 28;
  localparam int unsigned CordBits    = 32;
  localparam int unsigned AngBits     = 20;
  localparam int unsigned MaxColumns  = 1024;
  localparam int unsigned MaxRows     = 128;

  localparam logic [3:0] CfgTargetX = 4'd0;
  localparam logic [3:0] CfgTargetY = 4'd1;
  localparam logic [3:0] CfgTargetZ = 4'd2;
  localparam logic [3:0] CfgBoxX    = 4'd3;
  localparam logic [3:0] CfgBoxY    = 4'd4;
  localparam logic [3:0] CfgBoxZ    = 4'd5;
  localparam logic [3:0] CfgRows    = 4'd6;
  localparam logic [3:0] CfgColumns = 4'd7;

  localparam logic KindPixel = 1'b0;
  localparam logic KindFrame = 1'b1;

  typedef struct packed {
    logic       load;
    logic       sq;
    logic       sqrt_step;
    logic       cord_step;
    logic       save_az;
    logic       init_pol;
    logic       math;
    logic       finish;
    logic       frame;
    logic [3:0] idx;
  } lprbl_cmd_t;

  typedef struct packed {
    logic out_busy;
    logic frame_end;
  } lprbl_sts_t;

  function automatic logic signed [AngBits-1:0] atan_tab(input logic [3:0] i);
    logic signed [AngBits-1:0] v;
    case (i)
      4'd0:    v = 20'sd8192;
      4'd1:    v = 20'sd4836;
      4'd2:    v = 20'sd2555;
      4'd3:    v = 20'sd1297;
      4'd4:    v = 20'sd651;
      4'd5:    v = 20'sd326;
      4'd6:    v = 20'sd163;
      4'd7:    v = 20'sd81;
      4'd8:    v = 20'sd41;
      4'd9:    v = 20'sd20;
      4'd10:   v = 20'sd10;
      4'd11:   v = 20'sd5;
      4'd12:   v = 20'sd3;
      4'd13:   v = 20'sd1;
      4'd14:   v = 20'sd1;
      default: v = 20'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> sv/lprbl_ctrl.sv
// sequencer for the labeller: point accept, sqrt and cordic passes, result hand-off
// depends on lprbl_pkg
`default_nettype none
module lprbl_ctrl import lprbl_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  lprbl_sts_t sts_i,
  output lprbl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle, StSq, StRun, StPol, StPrun, StMath, StFin, StFrm
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    cmd_o.idx  = cnt_q[3:0];
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StSq;
        end
      end
      StSq: begin
        cmd_o.sq = 1'b1;
        cnt_d    = '0;
        state_d  = StRun;
      end
      StRun: begin
        // azimuth cordic runs its sixteen steps alongside the first sqrt steps
        cmd_o.sqrt_step = 1'b1;
        cmd_o.cord_step = (cnt_q < 5'd16);
        cmd_o.save_az   = (cnt_q == 5'd16);
        cnt_d           = cnt_q + 5'd1;
        if (cnt_q == 5'(SqrtSteps - 1)) state_d = StPol;
      end
      StPol: begin
        cmd_o.init_pol = 1'b1;
        cnt_d          = '0;
        state_d        = StPrun;
      end
      StPrun: begin
        cmd_o.cord_step = 1'b1;
        cnt_d           = cnt_q + 5'd1;
        if (cnt_q == 5'(CordicSteps - 1)) state_d = StMath;
      end
      StMath: begin
        cmd_o.math = 1'b1;
        state_d    = StFin;
      end
      StFin: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = sts_i.frame_end ? StFrm : StIdle;
        end
      end
      StFrm: begin
        if (!sts_i.out_busy) begin
          cmd_o.frame = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
`default_nettype wire

>>> sv/lprbl_dpath.sv
// datapath: squares, bit-serial sqrt, shared cordic, pixel mapping, box bounds, output reg
// depends on lprbl_pkg
`default_nettype none
module lprbl_dpath import lprbl_pkg::*; (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  lprbl_cmd_t                 cmd_i,
  output lprbl_sts_t                 sts_o,
  input  wire signed [CoordBits-1:0] px_i,
  input  wire signed [CoordBits-1:0] py_i,
  input  wire signed [CoordBits-1:0] pz_i,
  input  wire                        fe_i,
  input  wire signed [15:0]          tgt_x_i,
  input  wire signed [15:0]          tgt_y_i,
  input  wire signed [15:0]          tgt_z_i,
  input  wire        [14:0]          size_x_i,
  input  wire        [14:0]          size_y_i,
  input  wire        [14:0]          size_z_i,
  input  wire        [9:0]           wm1_i,
  input  wire        [7:0]           h_i,
  input  wire                        out_ready_i,
  output logic                       out_valid_o,
  output logic                       out_kind_o,
  output logic       [69:0]          out_data_o
);

  logic signed [CoordBits-1:0] px_q, py_q, pz_q;
  logic                        fe_q;
  logic [55:0]                 nsh_q;
  logic [31:0]                 rem_q;
  logic [SqrtSteps-1:0]        root_q;
  logic signed [CordBits-1:0]  cx_q, cy_q;
  logic signed [AngBits-1:0]   ang_q, az_q;
  logic                        czero_q;
  logic [26:0]                 colp_q;
  logic signed [28:0]          rowp_q;
  logic                        hit_q;
  logic [9:0]                  lcol_q, gcol_q;
  logic [6:0]                  lrow_q, grow_q;
  logic                        ov_q, okind_q;
  logic [69:0]                 odata_q;

  // squares and sum of x^2 + y^2 of the held point
  logic signed [31:0] sqx, sqy;
  logic [31:0]        sqsum;
  assign sqx   = px_q * px_q;
  assign sqy   = py_q * py_q;
  assign sqsum = 32'(sqx) + 32'(sqy);

  // one root bit per cycle
  logic [31:0] rem_sh, trial;
  assign rem_sh = {rem_q[29:0], nsh_q[55:54]};
  assign trial  = {2'b00, root_q, 2'b01};

  // cordic vectoring init
  logic signed [CordBits-1:0] ix, iy;
  always_comb begin
    if (cmd_i.init_pol) begin
      ix = CordBits'(pz_q) <<< ScaleShift;
      iy = CordBits'({1'b0, root_q});
    end else begin
      ix = CordBits'(px_q) <<< ScaleShift;
      iy = CordBits'(py_q) <<< ScaleShift;
    end
  end

  logic signed [CordBits-1:0] xsh, ysh;
  assign xsh = cx_q >>> cmd_i.idx;
  assign ysh = cy_q >>> cmd_i.idx;

  logic signed [AngBits-1:0] cord_res, theta;
  assign cord_res = czero_q ? '0 : ang_q;
  assign theta    = (pz_q == '0) ? 20'sd16384 : cord_res;

  // pixel mapping products
  logic signed [20:0] fdiff, tdiff;
  logic [16:0]        fcl;
  assign fdiff = 21'sd32768 - 21'(az_q);
  always_comb begin
    if (fdiff < 0)              fcl = '0;
    else if (fdiff > 21'sd65536) fcl = 17'd65536;
    else                        fcl = fdiff[16:0];
  end
  assign tdiff = 21'(theta) - 21'sd12288;

  logic [27:0]        colsum;
  logic [9:0]         col;
  logic signed [28:0] nval;
  logic [15:0]        rowfull;
  logic               view;
  logic [6:0]         row;
  assign colsum  = 28'(colp_q) + 28'd32768;
  assign col     = colsum[25:16];
  assign nval    = rowp_q + 29'sd4096;
  assign rowfull = 16'(nval >>> 13);
  assign view    = !nval[28] && (rowfull < 16'(h_i));
  assign row     = view ? rowfull[6:0] : '0;

  // strict box test in doubled units
  function automatic logic inside_f(input logic signed [15:0] p, input logic signed [15:0] c,
                                    input logic [14:0] s);
    logic signed [18:0] p2, c2, sz;
    p2 = 19'(p) <<< 1;
    c2 = 19'(c) <<< 1;
    sz = 19'({1'b0, s});
    return (p2 > c2 - sz) && (p2 < c2 + sz);
  endfunction

  logic box;
  assign box = inside_f(16'(px_q), tgt_x_i, size_x_i) && inside_f(16'(py_q), tgt_y_i, size_y_i)
               && inside_f(16'(pz_q), tgt_z_i, size_z_i);

  logic busy;
  assign busy            = ov_q && !out_ready_i;
  assign sts_o.out_busy  = busy;
  assign sts_o.frame_end = fe_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q <= px_i;
      py_q <= py_i;
      pz_q <= pz_i;
      fe_q <= fe_i;
    end
    if (cmd_i.sq) begin
      nsh_q <= {sqsum, 24'd0};
      rem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      nsh_q <= {nsh_q[53:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[SqrtSteps-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[SqrtSteps-2:0], 1'b0};
      end
    end
    if (cmd_i.sq || cmd_i.init_pol) begin
      czero_q <= (ix == '0) && (iy == '0);
      if (ix < 0) begin
        cx_q  <= -ix;
        cy_q  <= -iy;
        ang_q <= (iy >= 0) ? 20'sd32768 : -20'sd32768;
      end else begin
        cx_q  <= ix;
        cy_q  <= iy;
        ang_q <= '0;
      end
    end else if (cmd_i.cord_step) begin
      if (cy_q > 0) begin
        cx_q  <= cx_q + ysh;
        cy_q  <= cy_q - xsh;
        ang_q <= ang_q + atan_tab(cmd_i.idx);
      end else begin
        cx_q  <= cx_q - ysh;
        cy_q  <= cy_q + xsh;
        ang_q <= ang_q - atan_tab(cmd_i.idx);
      end
    end
    if (cmd_i.save_az) az_q <= cord_res;
    if (cmd_i.math) begin
      colp_q <= wm1_i * fcl;
      rowp_q <= $signed({1'b0, h_i - 8'd1}) * tdiff;
    end
    if (!busy && (cmd_i.finish || cmd_i.frame)) begin
      if (cmd_i.frame) begin
        okind_q <= KindFrame;
        odata_q <= hit_q ? {grow_q, gcol_q, lrow_q, lcol_q, 1'b1, 35'd0} : '0;
      end else begin
        okind_q <= KindPixel;
        odata_q <= {35'd0, box, view, 16'(px_q), row, col};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q   <= 1'b0;
      hit_q  <= 1'b0;
      lcol_q <= 10'd1023;
      gcol_q <= '0;
      lrow_q <= 7'd127;
      grow_q <= '0;
    end else begin
      if (!busy && (cmd_i.finish || cmd_i.frame)) ov_q <= 1'b1;
      else if (out_ready_i)                        ov_q <= 1'b0;
      if (cmd_i.finish && box && view) begin
        hit_q <= 1'b1;
        if (col < lcol_q) lcol_q <= col;
        if (col > gcol_q) gcol_q <= col;
        if (row < lrow_q) lrow_q <= row;
        if (row > grow_q) grow_q <= row;
      end else if (cmd_i.frame) begin
        hit_q  <= 1'b0;
        lcol_q <= 10'd1023;
        gcol_q <= '0;
        lrow_q <= 7'd127;
        grow_q <= '0;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_kind_o  = okind_q;
  assign out_data_o  = odata_q;

endmodule
`default_nettype wire

>>> sv/lidar_point_range_image_box_labeller_unit.sv
// Lidar point range-image projection with target box labelling.
// Input stream s_axis_*: one point per transfer, tdata = x, y, z (16 bits each,
// signed, 1/256 m), tlast marks the last point of a frame.
// Output stream m_axis_*: tuser = result kind (0 pixel, 1 frame bounds).
// Every point gives a pixel result; a tlast point adds a frame result after it.
// Config channel cfg_*: index 0..7 = target x/y/z, box size x/y/z, rows, columns;
// always ready, write only while the block is idle.
// Sequence: after a point is accepted, its pixel result passes through one
// square, 28 square-root steps (the azimuth cordic runs alongside), polar
// cordic (init plus 16 steps), one multiply and one output load. A new point
// is accepted in the cycle after the previous point's results are in the output
// register, so no new point is taken while one is in flight; a frame end adds
// a frame result, loaded once its pixel result has been taken.
// Stall: results are held in the output register while m_axis_tready is low,
// and the sequencer waits for it before loading the next result.
// Reset clears the frame bounds and restores register defaults; no clearing pass.
// depends on lprbl_pkg, lprbl_ctrl, lprbl_dpath
`default_nettype none
module lidar_point_range_image_box_labeller_unit import lprbl_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [47:0] s_axis_tdata,   // point_x, point_y, point_z
  input  wire         s_axis_tlast,   // frame_end
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [71:0] m_axis_tdata,   // pixel_column, pixel_row, depth_value, in_view,
                                      // in_box, box_found, box_left, box_top,
                                      // box_right, box_bottom, zero pad
  output logic        m_axis_tuser,   // result_kind
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [3:0]  cfg_index_i,
  input  wire  [15:0] cfg_data_i
);

  logic signed [15:0] tgt_x_q, tgt_y_q, tgt_z_q;
  logic [14:0]        size_x_q, size_y_q, size_z_q;
  logic [7:0]         rows_q;
  logic [10:0]        cols_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_x_q  <= '0;
      tgt_y_q  <= '0;
      tgt_z_q  <= '0;
      size_x_q <= 15'd166;
      size_y_q <= 15'd166;
      size_z_q <= 15'd115;
      rows_q   <= 8'd64;
      cols_q   <= 11'd1024;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgTargetX: tgt_x_q  <= cfg_data_i;
        CfgTargetY: tgt_y_q  <= cfg_data_i;
        CfgTargetZ: tgt_z_q  <= cfg_data_i;
        CfgBoxX:    size_x_q <= cfg_data_i[14:0];
        CfgBoxY:    size_y_q <= cfg_data_i[14:0];
        CfgBoxZ:    size_z_q <= cfg_data_i[14:0];
        CfgRows:    rows_q   <= cfg_data_i[7:0];
        CfgColumns: cols_q   <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize saturates
  logic [10:0] w_eff;
  logic [7:0]  h_eff;
  always_comb begin
    if (cols_q == '0)                    w_eff = 11'd1;
    else if (cols_q > 11'(MaxColumns))   w_eff = 11'(MaxColumns);
    else                                 w_eff = cols_q;
    if (rows_q == '0)                    h_eff = 8'd1;
    else if (rows_q > 8'(MaxRows))       h_eff = 8'(MaxRows);
    else                                 h_eff = rows_q;
  end

  logic [9:0] wm1;
  assign wm1 = 10'(w_eff - 11'd1);

  lprbl_cmd_t cmd;
  lprbl_sts_t sts;
  logic [69:0] odata;

  lprbl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lprbl_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .px_i        (s_axis_tdata[15:0]),
    .py_i        (s_axis_tdata[31:16]),
    .pz_i        (s_axis_tdata[47:32]),
    .fe_i        (s_axis_tlast),
    .tgt_x_i     (tgt_x_q),
    .tgt_y_i     (tgt_y_q),
    .tgt_z_i     (tgt_z_q),
    .size_x_i    (size_x_q),
    .size_y_i    (size_y_q),
    .size_z_i    (size_z_q),
    .wm1_i       (wm1),
    .h_i         (h_eff),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_kind_o  (m_axis_tuser),
    .out_data_o  (odata)
  );

  assign m_axis_tdata = {2'b00, odata};

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// self-checking testbench for the lidar range image box labeller
// predicts every pixel and frame-bounds result and compares them field by field
// depends on lprbl_pkg and lidar_point_range_image_box_labeller_unit
`default_nettype none
module testbench;
  import lprbl_pkg::*;

  localparam int WatchLimit = 20000;
  localparam int SettleCycles = 80;

  typedef struct {
    logic        kind;
    logic [9:0]  col;
    logic [6:0]  row;
    logic [15:0] depth;
    logic        view;
    logic        box;
    logic        found;
    logic [9:0]  left;
    logic [6:0]  top;
    logic [9:0]  right;
    logic [6:0]  bottom;
  } pix_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [3:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  lidar_point_range_image_box_labeller_unit dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  longint tgt_x, tgt_y, tgt_z, size_x, size_y, size_z;
  int unsigned rows_reg, cols_reg;
  logic hit_seen;
  logic [9:0] min_col, max_col;
  logic [6:0] min_row, max_row;

  pix_res_t pending_results[$];
  int errors = 0;
  int pixel_count = 0, frame_count = 0, box_hits = 0, found_frames = 0;
  int idle_pct = 0, stall_pct = 0;
  int quiet_cycles = 0;

  longint bin_atan[16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                            41, 20, 10, 5, 3, 1, 1, 0};

  function automatic longint vec_angle(input longint yv, input longint xv);
    longint ang, xt, yt;
    ang = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      ang = (yv >= 0) ? 32768 : -32768;
      xv = -xv;
      yv = -yv;
    end
    for (int i = 0; i < 16; i++) begin
      xt = xv >>> i;
      yt = yv >>> i;
      if (yv > 0) begin
        xv += yt; yv -= xt; ang += bin_atan[i];
      end else begin
        xv -= yt; yv += xt; ang -= bin_atan[i];
      end
    end
    return ang;
  endfunction

  function automatic longint int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic logic strictly_in(input longint p, input longint c, input longint sz);
    return (2 * p > 2 * c - sz) && (2 * p < 2 * c + sz);
  endfunction

  task automatic project_point(input logic signed [15:0] px, input logic signed [15:0] py,
                               input logic signed [15:0] pz, input logic last);
    longint xs, ys, zs, rho, az, f, theta, n;
    longint unsigned w, h, col, row;
    logic view, box;
    pix_res_t r, fr;
    xs = longint'(px) <<< 12;
    ys = longint'(py) <<< 12;
    zs = longint'(pz) <<< 12;
    w = (cols_reg == 0) ? 1 : (cols_reg > MaxColumns) ? MaxColumns : cols_reg;
    h = (rows_reg == 0) ? 1 : (rows_reg > MaxRows) ? MaxRows : rows_reg;
    rho = int_sqrt(longint'(xs * xs + ys * ys));
    az = vec_angle(ys, xs);
    f = 32768 - az;
    if (f < 0) f = 0;
    if (f > 65536) f = 65536;
    col = ((w - 1) * longint'(f) + 32768) >> 16;
    theta = (pz == 0) ? 16384 : vec_angle(rho, zs);
    n = longint'(h - 1) * (theta - 12288) + 4096;
    view = 1'b0;
    row = 0;
    if (n >= 0) begin
      row = longint'(n) >> 13;
      view = row < h;
    end
    if (!view) row = 0;
    box = strictly_in(px, tgt_x, size_x) && strictly_in(py, tgt_y, size_y)
          && strictly_in(pz, tgt_z, size_z);
    if (box && view) begin
      box_hits++;
      hit_seen = 1'b1;
      if (col < min_col) min_col = col[9:0];
      if (col > max_col) max_col = col[9:0];
      if (row < min_row) min_row = row[6:0];
      if (row > max_row) max_row = row[6:0];
    end
    r = '{KindPixel, col[9:0], row[6:0], px, view, box, 0, 0, 0, 0, 0};
    pending_results = {pending_results, r};
    if (last) begin
      fr = '{KindFrame, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
      if (hit_seen) begin
        found_frames++;
        fr.found = 1'b1;
        fr.left = min_col; fr.top = min_row; fr.right = max_col; fr.bottom = max_row;
      end
      pending_results = {pending_results, fr};
      hit_seen = 1'b0;
      min_col = 10'd1023; max_col = 0; min_row = 7'd127; max_row = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
  endtask

  // result checker
  always @(posedge clk_i) begin
    pix_res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, kind", m_axis_tuser, -1);
      end else begin
        e = pending_results.pop_front();
        if (e.kind == KindFrame) frame_count++; else pixel_count++;
        if (m_axis_tuser !== e.kind) report_mismatch("result_kind", m_axis_tuser, e.kind);
        if (m_axis_tdata[9:0] !== e.col) report_mismatch("pixel_column", m_axis_tdata[9:0], e.col);
        if (m_axis_tdata[16:10] !== e.row) report_mismatch("pixel_row", m_axis_tdata[16:10], e.row);
        if (m_axis_tdata[32:17] !== e.depth)
          report_mismatch("depth_value", m_axis_tdata[32:17], e.depth);
        if (m_axis_tdata[33] !== e.view) report_mismatch("in_view", m_axis_tdata[33], e.view);
        if (m_axis_tdata[34] !== e.box) report_mismatch("in_box", m_axis_tdata[34], e.box);
        if (m_axis_tdata[35] !== e.found) report_mismatch("box_found", m_axis_tdata[35], e.found);
        if (m_axis_tdata[45:36] !== e.left) report_mismatch("box_left", m_axis_tdata[45:36], e.left);
        if (m_axis_tdata[52:46] !== e.top) report_mismatch("box_top", m_axis_tdata[52:46], e.top);
        if (m_axis_tdata[62:53] !== e.right)
          report_mismatch("box_right", m_axis_tdata[62:53], e.right);
        if (m_axis_tdata[69:63] !== e.bottom)
          report_mismatch("box_bottom", m_axis_tdata[69:63], e.bottom);
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("watchdog expired with %0d results outstanding", pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // called at a rising edge; returns at the edge where the point was taken
  task automatic send_point(input logic [15:0] px, input logic [15:0] py,
                            input logic [15:0] pz, input logic last);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_axis_tdata <= {pz, py, px};
    s_axis_tlast <= last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    project_point(px, py, pz, last);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [15:0] val);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgTargetX: tgt_x = longint'(signed'(val));
      CfgTargetY: tgt_y = longint'(signed'(val));
      CfgTargetZ: tgt_z = longint'(signed'(val));
      CfgBoxX:    size_x = val[14:0];
      CfgBoxY:    size_y = val[14:0];
      CfgBoxZ:    size_z = val[14:0];
      CfgRows:    rows_reg = val[7:0];
      CfgColumns: cols_reg = val[10:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic setup_scene(input int tx, input int ty, input int tz, input int bx,
                             input int by, input int bz, input int nrows, input int ncols);
    drain_results();
    write_reg(CfgTargetX, tx[15:0]);
    write_reg(CfgTargetY, ty[15:0]);
    write_reg(CfgTargetZ, tz[15:0]);
    write_reg(CfgBoxX, bx[15:0]);
    write_reg(CfgBoxY, by[15:0]);
    write_reg(CfgBoxZ, bz[15:0]);
    write_reg(CfgRows, nrows[15:0]);
    write_reg(CfgColumns, ncols[15:0]);
  endtask

  task automatic test_directed();
    // reset config: box of 166 x 166 x 115 around the sensor
    send_point(16'h0000, 16'h0000, 16'h0000, 1'b0);   // origin azimuth, zero z
    send_point(16'd20, 16'd0, 16'd0, 1'b0);           // in box, in view
    send_point(16'hFFEC, 16'd30, 16'd10, 1'b0);       // negative x, in box
    send_point(16'd0, 16'd82, 16'd0, 1'b0);           // y just inside half extent
    send_point(16'd0, 16'd83, 16'd0, 1'b0);           // y on the edge
    send_point(16'd0, 16'd0, 16'd57, 1'b0);           // odd z extent, inside
    send_point(16'd0, 16'd0, 16'd58, 1'b1);           // outside; frame end
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    send_point(16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_point(16'h8000, 16'h0000, 16'h0000, 1'b0);   // azimuth at the seam
    send_point(16'h8000, 16'hFFFF, 16'h0000, 1'b0);
    send_point(16'h7FFF, 16'h8000, 16'h0001, 1'b0);
    send_point(16'd0, 16'd0, 16'h7FFF, 1'b0);         // straight up, out of band
    send_point(16'd0, 16'd0, 16'h8000, 1'b0);         // straight down
    send_point(16'd0, 16'd0, 16'd1, 1'b0);            // in box but out of view
    send_point(16'd1000, 16'd0, 16'd410, 1'b0);       // band edge region
    send_point(16'd1000, 16'd0, 16'hFE66, 1'b0);
    send_point(16'd1, 16'd1, 16'd0, 1'b1);
    send_point(16'd5, 16'd5, 16'd5, 1'b1);            // frame of a single point
    send_point(16'd9000, 16'd9000, 16'd9000, 1'b1);   // frame with no hit
  endtask

  task automatic test_image_extremes();
    // smallest image, widest box around the origin
    setup_scene(0, 0, 0, 32767, 32767, 32767, 1, 1);
    for (int i = 0; i < 8; i++)
      send_point(16'($urandom), 16'($urandom), 16'($urandom_range(200)), i == 7);
    // sizes of zero act as one, oversized ones saturate
    setup_scene(-32768, -32768, -32768, 0, 0, 0, 0, 0);
    send_point(16'h8001, 16'h8001, 16'h8001, 1'b0);
    send_point(16'h8000, 16'h8000, 16'h8000, 1'b1);
    setup_scene(32767, 32767, 32767, 1, 2, 3, 255, 2047);
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    send_point(16'd100, 16'hFF00, 16'd0, 1'b1);
    setup_scene(0, 0, 0, 4000, 4000, 4000, 128, 1024);
    for (int i = 0; i < 6; i++)
      send_point(16'($urandom_range(1500)), 16'($urandom_range(1500)),
                 16'($urandom_range(300)), i == 5);
  endtask

  task automatic random_points(input int count);
    logic [15:0] px, py, pz;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 60) begin
        // mostly near the target so bounds get exercised
        px = 16'(tgt_x + $signed($urandom_range(2 * size_x + 40)) - size_x - 20);
        py = 16'(tgt_y + $signed($urandom_range(2 * size_y + 40)) - size_y - 20);
        pz = 16'(tgt_z + $signed($urandom_range(2 * size_z + 40)) - size_z - 20);
      end else if ($urandom_range(1)) begin
        px = 16'($urandom);
        py = 16'($urandom);
        pz = 16'($signed($urandom_range(4000)) - 2000);
      end else begin
        px = 16'($urandom);
        py = 16'($urandom);
        pz = 16'($urandom);
      end
      send_point(px, py, pz, $urandom_range(19) == 0);
    end
  endtask

  task automatic test_random_phases();
    int tx, ty, tz;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 85; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 85; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      tx = $signed($urandom_range(6000)) - 3000;
      ty = $signed($urandom_range(6000)) - 3000;
      tz = $signed($urandom_range(600)) - 300;
      setup_scene(tx, ty, tz, $urandom_range(50, 1500), $urandom_range(50, 1500),
                  $urandom_range(20, 600), $urandom_range(1, 128), $urandom_range(1, 1024));
      random_points(250);
    end
  endtask

  task automatic test_sender_pause();
    idle_pct = 10;
    stall_pct = 30;
    random_points(10);
    // hold off until every outstanding result has been seen
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    random_points(10);
  endtask

  initial begin
    tgt_x = 0; tgt_y = 0; tgt_z = 0;
    size_x = 166; size_y = 166; size_z = 115;
    rows_reg = 64; cols_reg = 1024;
    hit_seen = 1'b0;
    min_col = 10'd1023; max_col = 0; min_row = 7'd127; max_row = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_image_extremes();
    test_random_phases();
    test_sender_pause();
    drain_results();
    $display("covered %0d pixel and %0d frame results, %0d in-box hits, %0d frames with a box",
             pixel_count, frame_count, box_hits, found_frames);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
